/* rtl/core/base64_stream_encoder_assert.svh */
// Assertion macros used by the Base64 stream encoder queue RTL.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while the reset is applied.
`define B64E_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("base64 encoder assertion failed");

// Clocked check that also holds during reset.
`define B64E_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("base64 encoder assertion failed");

`else

`define B64E_ASSERT(label, clk, rst_n, prop)
`define B64E_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/core/b64e_pkg.sv */
// Shared types, constants and the alphabet function of the Base64 stream encoder.
// Depends on nothing; the front, queue, back and top-level RTL files use it by scoped names.
package b64e_pkg;

    // Configuration register.
    localparam int LIMIT_W = 10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd76;

    // Line counter, saturating at its maximum.
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    // Byte phase within a triple.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // Characters other than the alphabet.
    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Number of characters one byte can cause.
    localparam int MAX_CHARS = 4;

    // One queue entry: the characters that one byte causes.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                cnt_m1;
        logic                      msg_end;
    } t_rec;

    // Map a six-bit value to its character of the standard alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

/* rtl/core/b64e_front.sv */
// Front of the Base64 stream encoder: takes bytes, keeps the encoding state
// and turns each byte into one queue entry. Depends on b64e_pkg.
module b64e_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [b64e_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_push,
    output b64e_pkg::t_rec                  o_rec,
    input  logic                            i_full
);

    logic [b64e_pkg::LIMIT_W-1:0] r_line_limit;
    logic [1:0]                   r_phase, n_phase;
    logic [3:0]                   r_carry, n_carry;
    logic [b64e_pkg::COUNT_W-1:0] r_count, n_count;
    logic [b64e_pkg::COUNT_W:0]   sum1, sum2;
    logic [b64e_pkg::COUNT_W-1:0] cnt1, cnt2;
    logic                         accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // Line count plus one or two characters, saturated.
    assign sum1 = {1'b0, r_count} + {{b64e_pkg::COUNT_W{1'b0}}, 1'b1};
    assign sum2 = {1'b0, r_count} + (b64e_pkg::COUNT_W+1)'(2);
    assign cnt1 = sum1[b64e_pkg::COUNT_W] ? b64e_pkg::COUNT_MAX
                                          : sum1[b64e_pkg::COUNT_W-1:0];
    assign cnt2 = sum2[b64e_pkg::COUNT_W] ? b64e_pkg::COUNT_MAX
                                          : sum2[b64e_pkg::COUNT_W-1:0];

    // Characters and next state for the byte on the input.
    always_comb begin
        o_rec         = '0;
        o_rec.msg_end = i_last_byte;
        n_phase       = r_phase;
        n_carry       = r_carry;
        n_count       = r_count;
        case (r_phase)
            b64e_pkg::PHASE_SECOND: begin
                o_rec.chars[0] = b64e_pkg::b64_char({r_carry[1:0], i_data_byte[7:4]});
                o_rec.cnt_m1   = 2'd0;
                n_count        = cnt1;
                n_carry        = i_data_byte[3:0];
                n_phase        = b64e_pkg::PHASE_THIRD;
                if (i_last_byte) begin
                    o_rec.chars[1] = b64e_pkg::b64_char({i_data_byte[3:0], 2'b00});
                    o_rec.chars[2] = b64e_pkg::CHAR_PAD;
                    o_rec.cnt_m1   = 2'd2;
                end
            end
            b64e_pkg::PHASE_THIRD: begin
                o_rec.chars[0] = b64e_pkg::b64_char({r_carry, i_data_byte[7:6]});
                o_rec.chars[1] = b64e_pkg::b64_char(i_data_byte[5:0]);
                o_rec.cnt_m1   = 2'd1;
                n_count        = cnt2;
                n_carry        = 4'd0;
                n_phase        = b64e_pkg::PHASE_FIRST;
                // Line break after a full group once the limit is reached.
                if ((r_line_limit != '0) &&
                    (cnt2 >= {1'b0, r_line_limit})) begin
                    o_rec.chars[2] = b64e_pkg::CHAR_CR;
                    o_rec.chars[3] = b64e_pkg::CHAR_LF;
                    o_rec.cnt_m1   = 2'd3;
                    n_count        = '0;
                end
            end
            default: begin
                // The unused phase code acts as the start of a triple.
                o_rec.chars[0] = b64e_pkg::b64_char(i_data_byte[7:2]);
                o_rec.cnt_m1   = 2'd0;
                n_count        = cnt1;
                n_carry        = {2'b00, i_data_byte[1:0]};
                n_phase        = b64e_pkg::PHASE_SECOND;
                if (i_last_byte) begin
                    o_rec.chars[1] = b64e_pkg::b64_char({i_data_byte[1:0], 4'b0000});
                    o_rec.chars[2] = b64e_pkg::CHAR_PAD;
                    o_rec.chars[3] = b64e_pkg::CHAR_PAD;
                    o_rec.cnt_m1   = 2'd3;
                end
            end
        endcase
        // The end of a message returns the state to its reset value.
        if (i_last_byte) begin
            n_phase = b64e_pkg::PHASE_FIRST;
            n_carry = 4'd0;
            n_count = '0;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= b64e_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_line_limit <= i_cfg_data;
        end
    end

    // Encoding state, updated on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PHASE_FIRST;
            r_carry <= 4'd0;
            r_count <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/core/b64e_queue.sv */
// Short queue of character groups between the front and the back.
// Depends on b64e_pkg and the assertion macro header.
`include "base64_stream_encoder_assert.svh"

module b64e_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output b64e_pkg::t_rec o_rec
);

    b64e_pkg::t_rec                r_mem [b64e_pkg::QUEUE_DEPTH];
    logic [b64e_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [b64e_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [b64e_pkg::QUEUE_CW-1:0] r_count;
    logic                          push_fire;
    logic                          pop_fire;

    assign o_full    = (r_count == b64e_pkg::QUEUE_CW'(b64e_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rec     = r_mem[r_rd_ptr];
    assign push_fire = i_push && !o_full;
    assign pop_fire  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + 1'b1;
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    `B64E_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= b64e_pkg::QUEUE_CW'(b64e_pkg::QUEUE_DEPTH))
    // An empty queue has both pointers at the same entry.
    `B64E_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
    // A push without a pop grows the queue by one entry.
    `B64E_ASSERT(a_push_grows, i_clk, i_rst_n, (push_fire && !pop_fire) |=> (r_count == $past(r_count) + 1'b1))

endmodule

/* rtl/core/b64e_back.sv */
// Back of the Base64 stream encoder: sends the characters of each queue
// entry one beat at a time through an output register. Depends on b64e_pkg.
module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  b64e_pkg::t_rec i_q_rec,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_char,
    output logic           o_run_last,
    output logic           o_message_end
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_char;
    logic       r_run_last;
    logic       r_msg_end;
    logic       load;
    logic       at_last;

    assign load    = i_q_valid && (!r_valid || i_ready);
    assign at_last = (r_idx == i_q_rec.cnt_m1);
    assign o_pop   = load && at_last;

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_run_last    = r_run_last;
    assign o_message_end = r_msg_end;

    // Output control: character index within the entry and the valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char     <= i_q_rec.chars[r_idx];
            r_run_last <= at_last;
            r_msg_end  <= at_last && i_q_rec.msg_end;
        end
    end

endmodule

/* rtl/core/base64_stream_encoder.sv */
// Top level of the Base64 stream encoder with line breaks.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Takes one message byte per beat and sends Base64 characters (A-Z a-z 0-9 + /),
// one per output beat, with '=' padding on a short final group and CR LF after
// a full group once the line count reaches the line limit (zero: no breaks,
// reset value 76). Each accepted byte causes one to four characters; the output
// side sends one character per cycle while the receiver is ready, so the single
// character output port limits the rate; a four-entry queue between the byte
// front end and the character sender lets bytes enter while characters drain.
// The user must write the line limit only while the block is idle; the block
// itself does not enforce it.
module base64_stream_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [b64e_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_last_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_out_char,
    output logic                         o_run_last,
    output logic                         o_message_end
);

    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;
    b64e_pkg::t_rec push_rec;
    b64e_pkg::t_rec head_rec;

    // Byte intake and classification.
    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_rec       (push_rec),
        .i_full      (full)
    );

    // Character group queue.
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    // Character sender.
    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_rec       (head_rec),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

endmodule

/* tb/sv/b64_check_pkg.sv */
// Scoreboard class for the Base64 stream encoder testbench: it predicts the encoded
// characters of every accepted byte and checks the output beats against them.
// Depends on b64e_pkg for the phase codes, the special characters and the reset limit.
package b64_check_pkg;

    // The standard alphabet, value 0 in the top byte.
    localparam logic [64*8-1:0] ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                            "abcdefghijklmnopqrstuvwxyz",
                                            "0123456789+/"};

    // One predicted output beat.
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_enc_char;

    class b64_encoding_checker;
        logic [b64e_pkg::LIMIT_W-1:0] line_limit;
        logic [1:0]                   phase;
        logic [3:0]                   carry;
        logic [b64e_pkg::COUNT_W-1:0] line_count;
        t_enc_char                    expected_chars[$];
        int mismatches;
        int bytes_seen;
        int chars_checked;
        int messages;
        int line_breaks;

        function new();
            line_limit    = b64e_pkg::LIMIT_RESET;
            phase         = b64e_pkg::PHASE_FIRST;
            carry         = 4'd0;
            line_count    = '0;
            mismatches    = 0;
            bytes_seen    = 0;
            chars_checked = 0;
            messages      = 0;
            line_breaks   = 0;
        endfunction

        function void set_limit(logic [b64e_pkg::LIMIT_W-1:0] value);
            line_limit = value;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function logic [7:0] encode6(logic [5:0] v);
            return ALPHABET[8*(63 - int'(v)) +: 8];
        endfunction

        // The line count saturates instead of wrapping.
        function void count_chars(int k);
            int sum;
            sum = int'(line_count) + k;
            if (sum > int'(b64e_pkg::COUNT_MAX)) begin
                line_count = b64e_pkg::COUNT_MAX;
            end else begin
                line_count = 11'(sum);
            end
        endfunction

        // Work out the characters that one accepted input beat causes.
        function void note_byte(logic [7:0] b, logic last);
            logic [7:0] chars [4];
            int         n;
            t_enc_char  e;
            bytes_seen++;
            case (phase)
                b64e_pkg::PHASE_SECOND: begin
                    chars[0] = encode6({carry[1:0], b[7:4]});
                    n = 1;
                    count_chars(1);
                    carry = b[3:0];
                    phase = b64e_pkg::PHASE_THIRD;
                    // Two bytes in the final group: one pad, and no line check.
                    if (last) begin
                        chars[1] = encode6({b[3:0], 2'b00});
                        chars[2] = b64e_pkg::CHAR_PAD;
                        n = 3;
                    end
                end
                b64e_pkg::PHASE_THIRD: begin
                    chars[0] = encode6({carry, b[7:6]});
                    chars[1] = encode6(b[5:0]);
                    n = 2;
                    count_chars(2);
                    carry = 4'd0;
                    phase = b64e_pkg::PHASE_FIRST;
                    // A full group may close the line, also on the last byte.
                    if (line_limit != '0 && line_count >= line_limit) begin
                        chars[2] = b64e_pkg::CHAR_CR;
                        chars[3] = b64e_pkg::CHAR_LF;
                        n = 4;
                        line_count = '0;
                        line_breaks++;
                    end
                end
                default: begin
                    // The unused phase value behaves as the first one.
                    chars[0] = encode6(b[7:2]);
                    n = 1;
                    count_chars(1);
                    carry = {2'b00, b[1:0]};
                    phase = b64e_pkg::PHASE_SECOND;
                    if (last) begin
                        chars[1] = encode6({b[1:0], 4'b0000});
                        chars[2] = b64e_pkg::CHAR_PAD;
                        chars[3] = b64e_pkg::CHAR_PAD;
                        n = 4;
                    end
                end
            endcase
            for (int i = 0; i < n; i++) begin
                e.ch       = chars[i];
                e.run_last = (i == n - 1);
                e.msg_end  = last && (i == n - 1);
                expected_chars.push_back(e);
            end
            if (last) begin
                phase      = b64e_pkg::PHASE_FIRST;
                carry      = 4'd0;
                line_count = '0;
                messages++;
            end
        endfunction

        // Compare one output beat with the oldest prediction.
        function void check_char(logic [7:0] ch, logic run_last, logic msg_end);
            t_enc_char want;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR at %0t: unexpected char %02h run_last=%0b message_end=%0b",
                             $time, ch, run_last, msg_end);
                end
            end else begin
                want = expected_chars.pop_front();
                if (want.ch !== ch || want.run_last !== run_last || want.msg_end !== msg_end)
                begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR at %0t: expected %02h %0b %0b, got %02h %0b %0b",
                                 $time, want.ch, want.run_last, want.msg_end,
                                 ch, run_last, msg_end);
                    end
                end
            end
        endfunction
    endclass

endpackage

/* tb/sv/base64_stream_encoder_tb.sv */
// Top-level testbench of the Base64 stream encoder: directed and random messages
// under several line limits and handshake mixes. Depends on b64e_pkg, b64_check_pkg
// and the base64_stream_encoder RTL.
module base64_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [b64e_pkg::LIMIT_W-1:0] i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [7:0]                   i_data_byte = 8'h00;
    logic                         i_last_byte = 1'b0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [7:0]                   o_out_char;
    logic                         o_run_last;
    logic                         o_message_end;

    b64_check_pkg::b64_encoding_checker chk = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    int msg_left = 0;
    int cycle_count = 0;

    base64_stream_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

    // Free-running clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random ready, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every accepted beat and register write is seen here, inputs before outputs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                chk.set_limit(i_cfg_data);
            end
            if (i_valid && o_ready) begin
                chk.note_byte(i_data_byte, i_last_byte);
            end
            if (o_valid && i_ready) begin
                chk.check_char(o_out_char, o_run_last, o_message_end);
            end
        end
    end

    // Offer one byte, with a random gap first, and wait until it is taken.
    task automatic offer_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted character has come out.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // The line limit is only changed while the block is idle.
    task automatic write_limit(input logic [b64e_pkg::LIMIT_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random bytes in messages of random length; a message may span calls.
    task automatic stream_bytes(input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            if (msg_left == 0) begin
                msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120)
                                                       : $urandom_range(1, 12);
            end
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            offer_byte(b, msg_left == 1);
            msg_left--;
        end
    endtask

    function automatic logic [b64e_pkg::LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 10'd1023;
            2:       return 10'd1;
            3:       return 10'd4;
            4:       return b64e_pkg::LIMIT_RESET;
            5:       return 10'($urandom_range(2, 24));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Main sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 66;

        // Final groups of one, two and three bytes with the reset limit.
        offer_byte(8'h00, 1'b1);
        offer_byte(8'hFF, 1'b1);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h00, 1'b1);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'hFF, 1'b1);

        // The last byte fills the line, so CR LF ends the message.
        write_limit(10'd4);
        offer_byte(8'hFB, 1'b0);
        offer_byte(8'hEF, 1'b0);
        offer_byte(8'hBE, 1'b1);

        // The limit drops below the count in the middle of a line.
        write_limit(10'd1023);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h10, 1'b0);
        offer_byte(8'h83, 1'b0);
        write_limit(10'd2);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h5A, 1'b1);

        // Random messages in three handshake mixes; limit changes may fall mid-message.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_limit(pick_limit());
            // The receiver stalls for a long time so the input side backs up.
            if (ph == 2) begin
                hold_req++;
            end
            stream_bytes(65);
            write_limit(pick_limit());
            stream_bytes(65);
        end
        if (msg_left > 0) begin
            stream_bytes(msg_left);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Encoded %0d bytes in %0d messages into %0d checked beats, %0d line breaks.",
                 chk.bytes_seen, chk.messages, chk.chars_checked, chk.line_breaks);
        $display("Line limits from 0 to 1023, three idle mixes and a long output stall.");
        if (chk.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* base64_stream_encoder.f */
+incdir+rtl/core
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
tb/sv/b64_check_pkg.sv
tb/sv/base64_stream_encoder_tb.sv
